### sv/sbf_pkg.sv
// Shared types and constants for the SBUS frame decoder.
`timescale 1ns / 1ps

package sbf_pkg;

	localparam int FRAME_BYTES  = 25;
	localparam int HIST_BYTES   = FRAME_BYTES - 1;
	localparam int FILL_W       = 5;
	localparam int CHAN_W       = 11;
	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_IDX_W   = 4;
	localparam int PAYLOAD_W    = CHAN_W * NUM_CHANNELS;

	localparam logic [7:0]            SYNC_START  = 8'h0F;
	localparam logic [7:0]            SYNC_END    = 8'h00;
	localparam logic [7:0]            LIMIT_RESET = 8'd4;
	localparam logic [FILL_W-1:0]     FILL_FULL   = FILL_W'(HIST_BYTES);
	localparam logic [CHAN_IDX_W-1:0] LAST_CHAN   = CHAN_IDX_W'(NUM_CHANNELS - 1);

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [7:0]           raw;
		logic [7:0]           stable;
	} frame_t;

endpackage

### sv/sbus_frame_decoder.sv
// Top level of the SBUS frame decoder.
// One received byte is taken per beat, one per clock cycle while in_stall is low. The
// byte that closes a valid 25-byte frame (0x0F first, 0x00 last) loads a frame buffer,
// and the sixteen channel results leave through the output register one per cycle while
// out_stall is low, each with the raw flag byte and the debounced flags. The frame
// buffer holds one frame: while it is still unloading, in_stall rises only when the
// window is full, so that the next byte could close another frame; since a frame spans
// 25 bytes this happens only when the output side stalls. No clearing pass runs after
// reset. debounce_limit_q resets to 4 and is written through cfg_wr_en.
`timescale 1ns / 1ps

module sbus_frame_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [7:0]                      cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sbf_pkg::CHAN_IDX_W-1:0]  channel_index,
	output logic [sbf_pkg::CHAN_W-1:0]      channel_value,
	output logic [7:0]                      raw_flags,
	output logic [7:0]                      stable_flags,
	output logic                            last
);

	logic [7:0]                    debounce_limit_q;
	logic                          accept;
	logic                          full;
	logic                          hit;
	logic                          busy;
	logic [sbf_pkg::PAYLOAD_W-1:0] payload;
	logic [7:0]                    raw;
	logic [7:0]                    stable;
	sbf_pkg::frame_t               frame;

	assign in_stall = busy && full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= sbf_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			debounce_limit_q <= cfg_wr_data;
		end
	end

	sbf_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.full    (full),
		.hit     (hit),
		.payload (payload),
		.raw     (raw)
	);

	sbf_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.hit    (hit),
		.raw    (raw),
		.limit  (debounce_limit_q),
		.stable (stable)
	);

	assign frame.payload = payload;
	assign frame.raw     = raw;
	assign frame.stable  = stable;

	sbf_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (hit),
		.frame         (frame),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.raw_flags     (raw_flags),
		.stable_flags  (stable_flags),
		.last          (last)
	);

endmodule

### sv/sbf_window.sv
// Byte history line, fill count and frame sync detection.
`timescale 1ns / 1ps

module sbf_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    rx_byte,
	output logic                          full,
	output logic                          hit,
	output logic [sbf_pkg::PAYLOAD_W-1:0] payload,
	output logic [7:0]                    raw
);

	logic [7:0]                  hist_q [sbf_pkg::HIST_BYTES];
	logic [sbf_pkg::FILL_W-1:0]  fill_q;

	// The incoming byte completes a full window; hist_q[0] is its first byte.
	assign full = (fill_q == sbf_pkg::FILL_FULL);
	assign hit  = accept && full && (hist_q[0] == sbf_pkg::SYNC_START) &&
	              (rx_byte == sbf_pkg::SYNC_END);
	assign raw  = hist_q[sbf_pkg::HIST_BYTES-1];

	always_comb begin
		for (int k = 0; k < sbf_pkg::PAYLOAD_W / 8; k++) begin
			payload[8*k +: 8] = hist_q[k+1];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < sbf_pkg::HIST_BYTES - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[sbf_pkg::HIST_BYTES-1] <= rx_byte;
		end
	end

	// After a frame the count restarts, so every stale byte is replaced before the next check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (hit) begin
				fill_q <= '0;
			end else if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

### sv/sbf_debounce.sv
// Flag byte debounce: accepted flags and change counter.
`timescale 1ns / 1ps

module sbf_debounce (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hit,
	input  logic [7:0] raw,
	input  logic [7:0] limit,
	output logic [7:0] stable
);

	logic [7:0] accepted_q;
	logic [7:0] count_q;
	logic       differ;
	logic       take;

	assign differ = (accepted_q != raw);
	assign take   = hit && differ && (count_q > limit);
	assign stable = take ? raw : accepted_q;

	// The counter is kept, not cleared, when the flags match again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= '0;
			count_q    <= '0;
		end else if (hit && differ) begin
			if (take) begin
				accepted_q <= raw;
				count_q    <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

### sv/sbf_emitter.sv
// Frame buffer that unloads sixteen channel beats through an output register.
`timescale 1ns / 1ps

module sbf_emitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  sbf_pkg::frame_t                 frame,
	output logic                            busy,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sbf_pkg::CHAN_IDX_W-1:0]  channel_index,
	output logic [sbf_pkg::CHAN_W-1:0]      channel_value,
	output logic [7:0]                      raw_flags,
	output logic [7:0]                      stable_flags,
	output logic                            last
);

	logic [sbf_pkg::PAYLOAD_W-1:0]   data_q;
	logic [7:0]                      raw_q;
	logic [7:0]                      stable_q;
	logic                            busy_q;
	logic [sbf_pkg::CHAN_IDX_W-1:0]  chan_q;
	logic                            out_valid_q;
	logic                            adv;

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign adv       = busy_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				chan_q <= '0;
			end else if (adv) begin
				chan_q <= chan_q + 1'b1;
				if (chan_q == sbf_pkg::LAST_CHAN) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Channels sit back to back in the payload, so each beat takes the low bits and shifts.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= frame.payload;
			raw_q    <= frame.raw;
			stable_q <= frame.stable;
		end else if (adv) begin
			data_q <= data_q >> sbf_pkg::CHAN_W;
		end
		if (adv) begin
			channel_index <= chan_q;
			channel_value <= data_q[sbf_pkg::CHAN_W-1:0];
			raw_flags     <= raw_q;
			stable_flags  <= stable_q;
			last          <= (chan_q == sbf_pkg::LAST_CHAN);
		end
	end

endmodule

### sv/sbf_checker.sv
// Port-level checks for the SBUS frame decoder, bound to the top level.
`timescale 1ns / 1ps

module sbf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [sbf_pkg::CHAN_IDX_W-1:0]  channel_index,
	input logic [sbf_pkg::CHAN_W-1:0]      channel_value,
	input logic                            last
);

	// The last flag marks exactly the final channel of a frame.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (channel_index == sbf_pkg::LAST_CHAN)))
		else $error("last does not match channel 15");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel_index) &&
		$stable(channel_value) && $stable(last))
		else $error("stalled output beat changed");

	// Input back-pressure only comes from a frame that is still unloading.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid || $past(in_valid && !in_stall))
		else $error("input stalled with no frame in flight");

	// A frame's first channel follows a beat that ended the previous frame or idle output.
	a_frame_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && (channel_index != '0))
		else $error("channel sequence broken inside a frame");

endmodule

bind sbus_frame_decoder sbf_checker u_sbf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.channel_index (channel_index),
	.channel_value (channel_value),
	.last          (last)
);

### tb/sbus_frame_decoder_test.sv
// Self-checking testbench for the SBUS frame decoder: byte stream in, channel beats out.
`timescale 1ns / 1ps

module sbus_frame_decoder_test;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES   = 20;

	typedef struct packed {
		logic [sbf_pkg::CHAN_IDX_W-1:0] index;
		logic [sbf_pkg::CHAN_W-1:0]     value;
		logic [7:0]                     raw;
		logic [7:0]                     stable;
		logic                           last;
	} channel_beat_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [7:0]                     cfg_wr_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     rx_byte;
	logic                           out_valid;
	logic                           out_stall;
	logic [sbf_pkg::CHAN_IDX_W-1:0] channel_index;
	logic [sbf_pkg::CHAN_W-1:0]     channel_value;
	logic [7:0]                     raw_flags;
	logic [7:0]                     stable_flags;
	logic                           last;

	// Decoder state as the testbench expects it to be.
	logic [7:0] rx_window [sbf_pkg::FRAME_BYTES];
	int         rx_fill;
	logic [7:0] held_flags;
	logic [7:0] flag_changes;
	logic [7:0] debounce_limit;

	channel_beat_t expected_channels [$];
	int            failures;
	int            bytes_sent;
	int            quiet_cycles;
	bit            in_gaps_on;
	bit            out_gaps_on;

	sbus_frame_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.raw_flags     (raw_flags),
		.stable_flags  (stable_flags),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void drop_oldest_byte();
		for (int i = 0; i < sbf_pkg::FRAME_BYTES - 1; i++) begin
			rx_window[i] = rx_window[i + 1];
		end
		rx_fill = sbf_pkg::FRAME_BYTES - 1;
	endfunction

	// Advances the expected decoder state by one byte and queues the channels of a frame.
	task automatic decode_rx_byte(input logic [7:0] b);
		logic [sbf_pkg::PAYLOAD_W-1:0] bits;
		logic [7:0]                    raw;
		channel_beat_t                 beat;
		if (rx_fill >= sbf_pkg::FRAME_BYTES) begin
			drop_oldest_byte();
		end
		rx_window[rx_fill] = b;
		rx_fill++;
		if (rx_fill < sbf_pkg::FRAME_BYTES) return;
		if (rx_window[0] != sbf_pkg::SYNC_START ||
				rx_window[sbf_pkg::FRAME_BYTES - 1] != sbf_pkg::SYNC_END) begin
			drop_oldest_byte();
			return;
		end
		raw = rx_window[23];
		if (held_flags != raw) begin
			if (flag_changes > debounce_limit) begin
				flag_changes = 8'd0;
				held_flags = raw;
			end else begin
				flag_changes = flag_changes + 8'd1;
			end
		end
		for (int i = 0; i < 22; i++) begin
			bits[i * 8 +: 8] = rx_window[i + 1];
		end
		for (int k = 0; k < sbf_pkg::NUM_CHANNELS; k++) begin
			beat.index  = sbf_pkg::CHAN_IDX_W'(k);
			beat.value  = bits[k * sbf_pkg::CHAN_W +: sbf_pkg::CHAN_W];
			beat.raw    = raw;
			beat.stable = held_flags;
			beat.last   = (k == sbf_pkg::NUM_CHANNELS - 1);
			expected_channels.push_back(beat);
		end
		foreach (rx_window[i]) rx_window[i] = 8'd0;
		rx_fill = 0;
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = in_gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		decode_rx_byte(b);
		bytes_sent++;
	endtask

	// Sends the first count bytes of a frame built from its parts.
	task automatic send_frame(input logic [sbf_pkg::PAYLOAD_W-1:0] payload,
			input logic [7:0] flags,
			input logic [7:0] start_byte = sbf_pkg::SYNC_START,
			input logic [7:0] end_byte = sbf_pkg::SYNC_END,
			input int count = sbf_pkg::FRAME_BYTES);
		logic [7:0] frame [sbf_pkg::FRAME_BYTES];
		frame[0] = start_byte;
		for (int i = 0; i < 22; i++) begin
			frame[i + 1] = payload[i * 8 +: 8];
		end
		frame[23] = flags;
		frame[24] = end_byte;
		for (int i = 0; i < count; i++) begin
			send_byte(frame[i]);
		end
	endtask

	function automatic logic [sbf_pkg::PAYLOAD_W-1:0] random_payload();
		logic [sbf_pkg::PAYLOAD_W-1:0] p;
		for (int i = 0; i < 22; i++) begin
			p[i * 8 +: 8] = 8'($urandom);
		end
		return p;
	endfunction

	task automatic drain_decoder();
		in_valid <= 1'b0;
		while (expected_channels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_debounce_limit(input logic [7:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en      <= 1'b0;
		debounce_limit = value;
	endtask

	task automatic test_channel_extremes();
		logic [sbf_pkg::PAYLOAD_W-1:0] p;
		send_frame('1, 8'hFF);
		for (int k = 0; k < sbf_pkg::NUM_CHANNELS; k++) begin
			p[k * sbf_pkg::CHAN_W +: sbf_pkg::CHAN_W] = k[0] ? 11'h2AA : 11'h555;
		end
		send_frame(p, 8'h00);
	endtask

	// A matching frame between two changed frames must not clear the change count.
	task automatic test_flag_debounce();
		drain_decoder();
		write_debounce_limit(8'd1);
		send_frame(random_payload(), 8'hA5);
		send_frame(random_payload(), held_flags);
		send_frame(random_payload(), 8'hA5);
	endtask

	// At the top limit the count can never exceed it, so no change is taken.
	task automatic test_limit_extremes();
		drain_decoder();
		write_debounce_limit(8'd255);
		repeat (2) send_frame(random_payload(), ~held_flags);
	endtask

	task automatic test_resync();
		repeat (5) send_byte(8'($urandom));
		send_frame(random_payload(), 8'h12, sbf_pkg::SYNC_START, 8'h80);
		send_frame(random_payload(), 8'h12);
		send_byte(sbf_pkg::SYNC_START);
		send_frame(random_payload(), 8'h34);
	endtask

	task automatic test_random_stream();
		int         target;
		int         kind;
		logic [7:0] flag_choices [2];
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		for (int phase = 0; phase < 3; phase++) begin
			drain_decoder();
			write_debounce_limit(phase == 2 ? 8'($urandom) : 8'($urandom_range(0, 6)));
			flag_choices[0] = 8'($urandom);
			flag_choices[1] = 8'($urandom);
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				if ($urandom_range(0, 4) == 0) in_gaps_on = !in_gaps_on;
				kind = $urandom_range(0, 9);
				if (kind <= 6) begin
					send_frame(random_payload(), flag_choices[$urandom_range(0, 1)]);
				end else if (kind == 7) begin
					start_byte = sbf_pkg::SYNC_START;
					end_byte   = sbf_pkg::SYNC_END;
					if ($urandom_range(0, 1)) begin
						start_byte = sbf_pkg::SYNC_START ^ (8'h01 << $urandom_range(0, 7));
					end else begin
						end_byte = 8'h01 << $urandom_range(0, 7);
					end
					send_frame(random_payload(), flag_choices[0], start_byte, end_byte);
				end else if (kind == 8) begin
					send_frame(random_payload(), flag_choices[1], sbf_pkg::SYNC_START,
						sbf_pkg::SYNC_END, $urandom_range(1, sbf_pkg::FRAME_BYTES - 1));
				end else begin
					repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
				end
			end
		end
	endtask

	// Receiver: while out_gaps_on is set, stalls a drawn number of cycles before each beat.
	initial begin : output_side
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = out_gaps_on ? $urandom_range(0, 4) : 0;
			if ($urandom_range(0, 39) == 0) out_gaps_on = !out_gaps_on;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		channel_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_channels.size() == 0) begin
				$error("unexpected channel beat: index %0d value %0d", channel_index,
					channel_value);
				failures++;
			end else begin
				want = expected_channels.pop_front();
				if (channel_index !== want.index) begin
					$error("channel_index: expected %0d, got %0d", want.index, channel_index);
					failures++;
				end
				if (channel_value !== want.value) begin
					$error("channel_value: expected %0d, got %0d", want.value, channel_value);
					failures++;
				end
				if (raw_flags !== want.raw) begin
					$error("raw_flags: expected %0h, got %0h", want.raw, raw_flags);
					failures++;
				end
				if (stable_flags !== want.stable) begin
					$error("stable_flags: expected %0h, got %0h", want.stable, stable_flags);
					failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = 8'd0;
		in_valid     = 1'b0;
		rx_byte      = 8'd0;
		out_stall    = 1'b0;
		failures     = 0;
		bytes_sent   = 0;
		quiet_cycles = 0;
		in_gaps_on   = 1'b1;
		out_gaps_on  = 1'b1;
		foreach (rx_window[i]) rx_window[i] = 8'd0;
		rx_fill        = 0;
		held_flags     = 8'd0;
		flag_changes   = 8'd0;
		debounce_limit = sbf_pkg::LIMIT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_channel_extremes();
		test_flag_debounce();
		test_limit_extremes();
		test_resync();
		test_random_stream();
		drain_decoder();
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sbus_frame_decoder.f
sv/sbf_pkg.sv
sv/sbf_window.sv
sv/sbf_debounce.sv
sv/sbf_emitter.sv
sv/sbus_frame_decoder.sv
sv/sbf_checker.sv
tb/sbus_frame_decoder_test.sv
